// File: rtl/core/rc4_kg_pkg.sv
// Shared types and constants of the RC4 keystream generator.
package rc4_kg_pkg;

  localparam int unsigned ByteWidth       = 8;
  localparam int unsigned PermDepth       = 256;
  localparam int unsigned KeyBytesDefault = 256;

  typedef logic [ByteWidth-1:0] byte_t;

  typedef enum logic {
    OP_LOAD_KEY = 1'b0,
    OP_GENERATE = 1'b1
  } op_e;

endpackage

// File: rtl/core/rc4_kg_if.sv
// Request and response channel interfaces of the RC4 keystream generator.
interface rc4_kg_req_if;
  logic                 valid;
  logic                 ready;
  logic                 op;
  rc4_kg_pkg::byte_t    key_byte;
  logic                 key_last;
  logic                 fresh_start;

  modport source (output valid, op, key_byte, key_last, fresh_start, input ready);
  modport sink   (input valid, op, key_byte, key_last, fresh_start, output ready);
endinterface

interface rc4_kg_rsp_if;
  logic                 valid;
  logic                 ready;
  rc4_kg_pkg::byte_t    out_byte;
  logic                 is_keystream;

  modport source (output valid, out_byte, is_keystream, input ready);
  modport sink   (input valid, out_byte, is_keystream, output ready);
endinterface

// File: rtl/core/rc4_kg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rc4_kg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rc4_keystream_generator_core.sv
// RC4 keystream generator: key loader, key-mixing pass and byte generator.
//
// Requests carry either a key byte or a generate command. A key byte gives no
// response unless it is marked last. The last key byte runs the mixing pass of
// 256 swap steps (states MIX_RD_I, MIX_RD_J, MIX_WR_I, MIX_WR_J each), then
// registers its acknowledge response in MIX_ACK. A generate request steps
// through GEN_RD_J, GEN_WR_I and GEN_WR_J and registers its keystream byte. In
// both cases the next request can be accepted once the response is registered,
// and the response waits while the output register holds a result not yet
// taken. The permutation RAM does one read and one write per cycle, so every
// swap step needs two reads and two writes in sequence. The permutation is
// identity after reset and after a fresh start without any clearing pass: a
// valid bit per entry makes an unwritten entry read as its own index. A result
// waiting in the output register does not block the next request.
module rc4_keystream_generator_core #(
  parameter int unsigned KEY_BYTES = rc4_kg_pkg::KeyBytesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rc4_kg_req_if.sink    req_i,
  rc4_kg_rsp_if.source  rsp_o
);

  localparam int unsigned PermAw = $clog2(rc4_kg_pkg::PermDepth);
  localparam int unsigned KeyAw  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned CntW   = $clog2(KEY_BYTES + 1);
  localparam logic [CntW-1:0] KeyMax = CntW'(KEY_BYTES);
  localparam logic [7:0] LastStep = 8'(rc4_kg_pkg::PermDepth - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEN_RD_J,
    ST_GEN_WR_I,
    ST_GEN_WR_J,
    ST_MIX_RD_I,
    ST_MIX_RD_J,
    ST_MIX_WR_I,
    ST_MIX_WR_J,
    ST_MIX_ACK
  } state_e;

  state_e                state_q;
  rc4_kg_pkg::byte_t     i_q, j_q, a_q, b_q, t_q;
  logic [7:0]            step_q;
  logic [KeyAw-1:0]      kidx_q;
  logic [CntW-1:0]       len_q;
  logic [CntW-1:0]       count_q;
  logic                  out_vld_q;
  rc4_kg_pkg::byte_t     out_byte_q;
  logic                  out_ks_q;

  logic [rc4_kg_pkg::PermDepth-1:0] valid_q;
  rc4_kg_pkg::byte_t     rd_addr_q;
  logic                  rd_vld_q;

  logic                  req_acc;
  logic                  slot_free;
  logic                  fresh_clr;
  logic                  out_set;

  logic                  perm_we;
  rc4_kg_pkg::byte_t     perm_waddr, perm_wdata, perm_raddr, perm_rdata, perm_eff;
  rc4_kg_pkg::byte_t     gen_byte;

  logic                  key_we;
  rc4_kg_pkg::byte_t     key_rdata;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign slot_free   = !out_vld_q || rsp_o.ready;
  assign out_set     = ((state_q == ST_GEN_WR_J) || (state_q == ST_MIX_ACK)) && slot_free;
  assign fresh_clr   = req_acc && (req_i.op == rc4_kg_pkg::OP_LOAD_KEY) &&
                       req_i.key_last && req_i.fresh_start;
  assign key_we      = req_acc && (req_i.op == rc4_kg_pkg::OP_LOAD_KEY) &&
                       (count_q < KeyMax);

  // Entries never written since reset or a fresh start hold their own index.
  assign perm_eff = rd_vld_q ? perm_rdata : rd_addr_q;

  always_comb begin
    perm_we    = 1'b0;
    perm_waddr = i_q;
    perm_wdata = perm_eff;
    case (state_q)
      ST_IDLE:     perm_raddr = 8'(i_q + 8'd1);
      ST_GEN_RD_J: perm_raddr = 8'(j_q + perm_eff);
      ST_GEN_WR_I: perm_raddr = 8'(a_q + perm_eff);
      ST_GEN_WR_J: perm_raddr = t_q;
      ST_MIX_RD_I: perm_raddr = 8'(i_q + 8'd1);
      ST_MIX_RD_J: perm_raddr = 8'(j_q + perm_eff + key_rdata);
      default:     perm_raddr = i_q;
    endcase
    case (state_q)
      ST_GEN_WR_I, ST_MIX_WR_I: begin
        perm_we = 1'b1;
      end
      ST_GEN_WR_J, ST_MIX_WR_J: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = a_q;
      end
      default: begin
        perm_we = 1'b0;
      end
    endcase
  end

  // Entries i and j were just swapped, so the RAM copy of them may be stale.
  always_comb begin
    if (t_q == j_q) begin
      gen_byte = a_q;
    end else if (t_q == i_q) begin
      gen_byte = b_q;
    end else begin
      gen_byte = perm_eff;
    end
  end

  rc4_kg_ram #(
    .WIDTH (rc4_kg_pkg::ByteWidth),
    .DEPTH (rc4_kg_pkg::PermDepth)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (perm_we),
    .waddr_i (perm_waddr[PermAw-1:0]),
    .wdata_i (perm_wdata),
    .raddr_i (perm_raddr[PermAw-1:0]),
    .rdata_o (perm_rdata)
  );

  rc4_kg_ram #(
    .WIDTH (rc4_kg_pkg::ByteWidth),
    .DEPTH (KEY_BYTES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (count_q[KeyAw-1:0]),
    .wdata_i (req_i.key_byte),
    .raddr_i (kidx_q),
    .rdata_o (key_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_addr_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_addr_q <= perm_raddr;
      rd_vld_q  <= valid_q[perm_raddr[PermAw-1:0]];
      if (fresh_clr) begin
        valid_q <= '0;
      end else if (perm_we) begin
        valid_q[perm_waddr[PermAw-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      a_q        <= '0;
      b_q        <= '0;
      t_q        <= '0;
      step_q     <= '0;
      kidx_q     <= '0;
      len_q      <= '0;
      count_q    <= '0;
      out_vld_q  <= 1'b0;
      out_byte_q <= '0;
      out_ks_q   <= 1'b0;
    end else begin
      if (out_set) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            if (req_i.op == rc4_kg_pkg::OP_GENERATE) begin
              i_q     <= 8'(i_q + 8'd1);
              state_q <= ST_GEN_RD_J;
            end else begin
              if (key_we) begin
                count_q <= CntW'(count_q + 1'b1);
              end
              if (req_i.key_last) begin
                len_q   <= key_we ? CntW'(count_q + 1'b1) : count_q;
                kidx_q  <= '0;
                step_q  <= '0;
                i_q     <= req_i.fresh_start ? 8'hff : 8'(i_q - 8'd1);
                j_q     <= req_i.fresh_start ? 8'h00 : j_q;
                state_q <= ST_MIX_RD_I;
              end
            end
          end
        end
        ST_GEN_RD_J: begin
          a_q     <= perm_eff;
          j_q     <= 8'(j_q + perm_eff);
          state_q <= ST_GEN_WR_I;
        end
        ST_GEN_WR_I: begin
          b_q     <= perm_eff;
          t_q     <= perm_raddr;
          state_q <= ST_GEN_WR_J;
        end
        ST_GEN_WR_J: begin
          if (slot_free) begin
            out_byte_q <= gen_byte;
            out_ks_q   <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        ST_MIX_RD_I: begin
          i_q     <= 8'(i_q + 8'd1);
          state_q <= ST_MIX_RD_J;
        end
        ST_MIX_RD_J: begin
          a_q     <= perm_eff;
          j_q     <= perm_raddr;
          state_q <= ST_MIX_WR_I;
        end
        ST_MIX_WR_I: begin
          state_q <= ST_MIX_WR_J;
        end
        ST_MIX_WR_J: begin
          step_q <= 8'(step_q + 8'd1);
          kidx_q <= (CntW'(kidx_q) + CntW'(1) == len_q) ? '0 : KeyAw'(kidx_q + 1'b1);
          if (step_q == LastStep) begin
            j_q     <= i_q;
            count_q <= '0;
            state_q <= ST_MIX_ACK;
          end else begin
            state_q <= ST_MIX_RD_I;
          end
        end
        ST_MIX_ACK: begin
          if (slot_free) begin
            out_byte_q <= '0;
            out_ks_q   <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.out_byte     = out_byte_q;
  assign rsp_o.is_keystream = out_ks_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= KeyMax)
    else $error("key count exceeds the key store depth");

  a_ack_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX_ACK) |-> (count_q == '0))
    else $error("key count not cleared after the mixing pass");

  a_ack_j_eq_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX_ACK) |-> (j_q == i_q))
    else $error("index j differs from index i after the mixing pass");

  a_write_in_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    perm_we |-> (state_q == ST_GEN_WR_I || state_q == ST_GEN_WR_J ||
                 state_q == ST_MIX_WR_I || state_q == ST_MIX_WR_J))
    else $error("permutation written outside a swap step");
`endif

endmodule
